/* rtl/image_sample_color_map_macros.svh */
// Assertion macros used by the top-level mapper.
`ifndef IMAGE_SAMPLE_COLOR_MAP_MACROS_SVH
`define IMAGE_SAMPLE_COLOR_MAP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ISCM_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ISCM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/iscm_pkg.sv */
package iscm_pkg;

	localparam int TableRowsDefault = 256;
	localparam int MaxComponentsDefault = 4;
	localparam int NumRegs = 8;
	localparam int AddrW = 6;
	localparam int Lat = 12;

	typedef enum logic [2:0] {
		REG_PATH = 3'd0, REG_MODE = 3'd1, REG_COUNT = 3'd2, REG_EXP = 3'd3,
		REG_C0LO = 3'd4, REG_C0HI = 3'd5, REG_C1LO = 3'd6, REG_C1HI = 3'd7
	} reg_idx_t;

	localparam logic [2:0] PATH_IDENT = 3'd0;
	localparam logic [2:0] PATH_FUNC = 3'd1;
	localparam logic [2:0] PATH_PAL = 3'd2;
	localparam logic [2:0] PATH_DEC = 3'd3;
	localparam logic [2:0] PATH_AVG = 3'd4;

	localparam logic [1:0] MODE_GRAY = 2'd0;
	localparam logic [1:0] MODE_RGB = 2'd1;
	localparam logic [1:0] MODE_CMYK = 2'd2;

	localparam logic CMD_CONVERT = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] sample_zero;
		logic [7:0] sample_one;
		logic [7:0] sample_two;
		logic [7:0] sample_three;
		logic [7:0] entry_index;
		logic [1:0] entry_component;
		logic [7:0] entry_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  path_select;
		logic [1:0]  color_mode;
		logic [2:0]  count;
		logic [3:0]  exponent;
		logic [63:0] c0_lo;
		logic [63:0] c0_hi;
		logic [63:0] c1_lo;
		logic [63:0] c1_hi;
	} cfg_t;

	// Signed 16.16 product rounded to nearest, kept at 32 bits.
	function automatic logic [31:0] fxmul(input logic [31:0] a, input logic [31:0] b);
		logic signed [63:0] p;
		p = $signed(a) * $signed(b) + 64'sd32768;
		return p[47:16];
	endfunction

	function automatic logic [7:0] sub_floor(input logic [7:0] c, input logic [7:0] k);
		logic [8:0] s;
		s = {1'b0, c} + {1'b0, k};
		return (s >= 9'd255) ? 8'd0 : 8'(9'd255 - s);
	endfunction

	function automatic out_item_t emit(input logic [1:0] mode, input logic [31:0] v);
		out_item_t o;
		case (mode)
			MODE_GRAY: o = '{v[7:0], v[7:0], v[7:0]};
			MODE_RGB: o = '{v[7:0], v[15:8], v[23:16]};
			MODE_CMYK: o = '{sub_floor(v[7:0], v[31:24]), sub_floor(v[15:8], v[31:24]),
				sub_floor(v[23:16], v[31:24])};
			default: o = '0;
		endcase
		return o;
	endfunction

endpackage

/* rtl/iscm_front.sv */
// Front end: accepts requests and pushes every one of them into the work queue,
// so table writes and conversions reach the back end in the order they arrived.
module iscm_front (
	input  logic                in_valid,
	output logic                in_ready,
	input  iscm_pkg::in_item_t  in_item,
	output logic                push,
	output iscm_pkg::in_item_t  push_item,
	input  logic                q_full
);
	import iscm_pkg::*;

	assign in_ready = !q_full;
	assign push = in_valid && in_ready;
	assign push_item = in_item;
endmodule

/* rtl/iscm_queue.sv */
// Small FIFO between front and back ends.
module iscm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  iscm_pkg::in_item_t push_item,
	output logic               full,
	output logic               nempty,
	input  logic               pop,
	output iscm_pkg::in_item_t head
);
	import iscm_pkg::*;

	in_item_t   mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full = (cnt_q == 3'd4);
	assign nempty = (cnt_q != 3'd0);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 2'd1;
			end
			if (pop) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end
endmodule

/* rtl/iscm_back.sv */
// Back end: table lookup, tint pipeline, result FIFO with credit control.
module iscm_back #(
	parameter int TABLE_ROWS = iscm_pkg::TableRowsDefault,
	parameter int MAX_COMPONENTS = iscm_pkg::MaxComponentsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  iscm_pkg::cfg_t      cfg,
	input  logic                q_nempty,
	output logic                q_pop,
	input  iscm_pkg::in_item_t  q_head,
	output logic                out_valid,
	input  logic                out_ready,
	output iscm_pkg::out_item_t out_item,
	output logic                busy
);
	import iscm_pkg::*;

	localparam int RW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
	localparam int L = Lat;
	localparam int FD = L + 2;
	localparam int FW = $clog2(FD + 1);

	// One memory per column; each read at one address a cycle.
	logic [7:0] col_mem [MAX_COMPONENTS][TABLE_ROWS];
	logic [7:0] rd_s1 [4];

	// Pipeline valid and per-stage payload.
	logic       v_q [L];
	in_item_t   it_s1;
	logic [31:0] tp_q [L];
	logic [3:0]  e_q [L];
	logic [31:0] lk_q [L];

	logic [FW-1:0] cred_q;
	logic          take;
	logic          head_wr;
	logic          conv_take;
	logic          wr_en;

	// Table writes need no result slot, so they leave the queue without a credit.
	assign head_wr = (q_head.command == CMD_WRITE);
	assign take = q_nempty && (head_wr || (cred_q != '0));
	assign conv_take = take && !head_wr;
	assign wr_en = take && head_wr;
	assign q_pop = take;

	// Table storage.
	for (genvar c = 0; c < 4; c++) begin : g_col
		if (c < MAX_COMPONENTS) begin : g_on
			always_ff @(posedge clk) begin
				if (wr_en && (32'(q_head.entry_component) == c) &&
						(32'(q_head.entry_index) < TABLE_ROWS)) begin
					col_mem[c][q_head.entry_index[RW-1:0]] <= q_head.entry_value;
				end
			end
			logic [7:0] s;
			assign s = (c == 0) ? q_head.sample_zero : (c == 1) ? q_head.sample_one :
				(c == 2) ? q_head.sample_two : q_head.sample_three;
			logic [7:0] a;
			assign a = (cfg.path_select == PATH_DEC || cfg.path_select == PATH_AVG) ? s :
				q_head.sample_zero;
			logic inr;
			assign inr = (32'(a) < TABLE_ROWS);
			always_ff @(posedge clk) begin
				rd_s1[c] <= inr ? col_mem[c][a[RW-1:0]] : 8'd0;
			end
		end else begin : g_off
			always_ff @(posedge clk) begin
				rd_s1[c] <= 8'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (conv_take) begin
			it_s1 <= q_head;
		end
	end

	// Stage 2: form t and the non-function results.
	logic [31:0] lk_c;
	logic [9:0]  sum;
	logic [2:0]  n;
	logic [7:0]  avg;
	always_comb begin
		n = (cfg.count == 3'd0) ? 3'd1 :
			(32'(cfg.count) > MAX_COMPONENTS) ? 3'(MAX_COMPONENTS) : cfg.count;
		sum = 10'(rd_s1[0]) + ((n > 3'd1) ? 10'(rd_s1[1]) : 10'd0) +
			((n > 3'd2) ? 10'(rd_s1[2]) : 10'd0) + ((n > 3'd3) ? 10'(rd_s1[3]) : 10'd0);
		case (n)
			3'd2: avg = 8'(sum >> 1);
			3'd3: avg = 8'((20'(sum) * 20'd683) >> 11);
			3'd4: avg = 8'(sum >> 2);
			default: avg = 8'(sum);
		endcase
		lk_c = {rd_s1[3], rd_s1[2], rd_s1[1], rd_s1[0]};
	end

	// Decode of one sample lives outside table range as zero for the column mapping.
	out_item_t dir_c;
	always_comb begin
		case (it_s1.command == CMD_CONVERT ? cfg.path_select : 3'd7)
			PATH_IDENT: dir_c = emit(cfg.color_mode, {it_s1.sample_three, it_s1.sample_two,
				it_s1.sample_one, it_s1.sample_zero});
			PATH_PAL: dir_c = '{rd_s1[0], rd_s1[1], rd_s1[2]};
			PATH_DEC: dir_c = emit(cfg.color_mode, lk_c);
			PATH_AVG: dir_c = '{8'(8'd255 - avg), 8'(8'd255 - avg), 8'(8'd255 - avg)};
			default: dir_c = '0;
		endcase
	end

	// t = (tint<<16)/255, via reciprocal: x*16843010>>32 plus correction.
	logic [31:0] tdiv;
	logic [31:0] tnum;
	logic [55:0] tq;
	always_comb begin
		tnum = {8'd0, rd_s1[0], 16'd0};
		tq = 56'(tnum) * 56'd16843010;
		tdiv = 32'(tq[48:32]);
		if (tnum - tdiv * 32'd255 >= 32'd255) begin
			tdiv = tdiv + 32'd1;
		end
	end

	// Stage chain: index 0 is stage 2; exponent steps on indices 1..7.
	out_item_t dir_q [L];
	always_ff @(posedge clk) begin
		dir_q[0] <= dir_c;
		tp_q[0] <= tdiv;
		lk_q[0] <= tdiv;
		e_q[0] <= cfg.exponent;
		for (int i = 1; i < L; i++) begin
			dir_q[i] <= dir_q[i-1];
			lk_q[i] <= lk_q[i-1];
			e_q[i] <= e_q[i-1];
			if (i <= 7 && e_q[i-1] >= 4'd2 && e_q[i-1] <= 4'd8 && 32'(e_q[i-1]) > i) begin
				tp_q[i] <= fxmul(tp_q[i-1], lk_q[i-1]);
			end else begin
				tp_q[i] <= tp_q[i-1];
			end
		end
	end

	// Per component tail: stage 8 multiply, 9 add, 10 scale, 11 clamp.
	logic [31:0] m_s9 [4];
	logic [31:0] w_s10 [4];
	logic [7:0]  y_s11 [4];
	logic [31:0] fx_y;
	for (genvar j = 0; j < 4; j++) begin : g_fn
		logic [31:0] c0, c1;
		assign c0 = (j == 0) ? cfg.c0_lo[31:0] : (j == 1) ? cfg.c0_lo[63:32] :
			(j == 2) ? cfg.c0_hi[31:0] : cfg.c0_hi[63:32];
		assign c1 = (j == 0) ? cfg.c1_lo[31:0] : (j == 1) ? cfg.c1_lo[63:32] :
			(j == 2) ? cfg.c1_hi[31:0] : cfg.c1_hi[63:32];
		logic [31:0] ad_s;
		always_ff @(posedge clk) begin
			m_s9[j] <= fxmul(tp_q[7], c1 - c0);
			ad_s <= c0 + m_s9[j];
			w_s10[j] <= fxmul(ad_s, 32'h00FF_0000);
		end
		// Components beyond the active count are always zero.
		always_comb begin
			if (32'(j) >= 32'(n)) begin
				y_s11[j] = 8'd0;
			end else if (w_s10[j][31]) begin
				y_s11[j] = 8'd0;
			end else if (w_s10[j][30:24] != '0) begin
				y_s11[j] = 8'd255;
			end else begin
				y_s11[j] = w_s10[j][23:16];
			end
		end
		assign fx_y[8*j +: 8] = y_s11[j];
	end

	// Final stage select.
	out_item_t res_c;
	logic      isfn_q [L];
	always_ff @(posedge clk) begin
		isfn_q[0] <= (cfg.path_select == PATH_FUNC);
		for (int i = 1; i < L; i++) begin
			isfn_q[i] <= isfn_q[i-1];
		end
	end
	assign res_c = isfn_q[10] ? emit(cfg.color_mode, fx_y) : dir_q[10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L; i++) begin
				v_q[i] <= 1'b0;
			end
		end else begin
			v_q[0] <= conv_take;
			for (int i = 1; i < L; i++) begin
				v_q[i] <= v_q[i-1];
			end
		end
	end

	// Result FIFO sized for every in-flight item.
	out_item_t      ofifo_q [FD];
	logic [FW-1:0]  owp_q, orp_q, ocnt_q;
	logic           opop;
	assign out_valid = (ocnt_q != '0);
	assign out_item = ofifo_q[orp_q];
	assign opop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (v_q[11]) begin
			ofifo_q[owp_q] <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= '0;
			orp_q <= '0;
			ocnt_q <= '0;
			cred_q <= FW'(FD);
		end else begin
			if (v_q[11]) begin
				owp_q <= (owp_q == FW'(FD - 1)) ? '0 : owp_q + 1'b1;
			end
			if (opop) begin
				orp_q <= (orp_q == FW'(FD - 1)) ? '0 : orp_q + 1'b1;
			end
			ocnt_q <= ocnt_q + FW'(v_q[11]) - FW'(opop);
			cred_q <= cred_q - FW'(conv_take) + FW'(opop);
		end
	end

	logic anyv;
	always_comb begin
		anyv = 1'b0;
		for (int i = 0; i < L; i++) begin
			anyv = anyv | v_q[i];
		end
	end
	assign busy = anyv || out_valid;
endmodule

/* rtl/image_sample_color_map.sv */
// Image sample colour mapper. Each request either writes one byte of the
// decode table (256 rows by 4 columns) or converts one pixel of up to four
// samples to RGB along the path chosen by path_select. A request is taken
// every cycle while the four-deep work queue has room; table writes travel
// through the same queue, so a conversion always sees exactly the writes
// that were accepted before it. After it leaves the queue, a conversion
// result passes through the tint pipeline
// (table read, seven exponent multiplies, then coefficient multiply, add
// and scale). All paths share that pipeline so results stay in order.
// Results wait in a result FIFO sized for every item in flight, so a
// stalled consumer only stops the queue, never loses data. Table entries
// must be written before they are read; they are not cleared at reset.
// Registers must be written through the APB port only while no request is
// outstanding, a rule on the user that the block itself does not enforce.
module image_sample_color_map #(
	parameter int TABLE_ROWS = iscm_pkg::TableRowsDefault,
	parameter int MAX_COMPONENTS = iscm_pkg::MaxComponentsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  iscm_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output iscm_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);
	import iscm_pkg::*;
	`include "image_sample_color_map_macros.svh"

	cfg_t       cfg_q;
	logic       push, q_full, q_nempty, q_pop, busy;
	in_item_t   push_item, q_head;
	logic       cfg_wr;
	reg_idx_t   ridx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign ridx = reg_idx_t'(paddr[5:3]);

	// Register file; registers sit on 8-byte boundaries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{3'd0, 2'd0, 3'd1, 4'd1, 64'd0, 64'd0,
				64'h0001_0001_0001_0000, 64'h0001_0001_0001_0000};
		end else if (cfg_wr && paddr[2:0] == 3'd0) begin
			case (ridx)
				REG_PATH: cfg_q.path_select <= pwdata[2:0];
				REG_MODE: cfg_q.color_mode <= pwdata[1:0];
				REG_COUNT: cfg_q.count <= pwdata[2:0];
				REG_EXP: cfg_q.exponent <= pwdata[3:0];
				REG_C0LO: cfg_q.c0_lo <= pwdata;
				REG_C0HI: cfg_q.c0_hi <= pwdata;
				REG_C1LO: cfg_q.c1_lo <= pwdata;
				REG_C1HI: cfg_q.c1_hi <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_PATH: prdata = 64'(cfg_q.path_select);
			REG_MODE: prdata = 64'(cfg_q.color_mode);
			REG_COUNT: prdata = 64'(cfg_q.count);
			REG_EXP: prdata = 64'(cfg_q.exponent);
			REG_C0LO: prdata = cfg_q.c0_lo;
			REG_C0HI: prdata = cfg_q.c0_hi;
			REG_C1LO: prdata = cfg_q.c1_lo;
			REG_C1HI: prdata = cfg_q.c1_hi;
			default: prdata = '0;
		endcase
	end

	iscm_front u_front (
		.in_valid, .in_ready, .in_item(in_data), .push, .push_item, .q_full
	);

	iscm_queue u_queue (
		.clk, .arst_n, .push, .push_item, .full(q_full), .nempty(q_nempty),
		.pop(q_pop), .head(q_head)
	);

	iscm_back #(.TABLE_ROWS(TABLE_ROWS), .MAX_COMPONENTS(MAX_COMPONENTS)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_nempty,
		.q_pop, .q_head, .out_valid, .out_ready, .out_item(out_data), .busy
	);

	// The queue is never popped empty nor pushed when full.
	`ISCM_ASSERT_IMPL(a_no_underflow, q_pop, q_nempty)
	`ISCM_ASSERT_IMPL(a_no_overflow, push, !q_full)
	// A held result stays on the port until taken.
	`ISCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	// Registers must only change while the block holds no request; this checks the user.
	`ISCM_ASSERT_IMPL(a_cfg_idle, cfg_wr, !busy && !q_nempty)
endmodule

/* tb/sv/iscm_checker.sv */
`timescale 1ns / 1ps

// Watches the request, result and register ports, predicts each converted pixel and
// compares it with what the block returns.
module iscm_checker
	import iscm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	input  logic      psel,
	input  logic      penable,
	input  logic      pwrite,
	input  logic [5:0] paddr,
	input  logic [63:0] pwdata,
	input  logic      pready,
	output int        fail_count,
	output int        pending
);

	logic [7:0] decode_rows [256][4];
	logic [2:0] path_sel;
	logic [1:0] space_sel;
	logic [2:0] comp_count;
	logic [3:0] exp_n;
	logic [63:0] c0_lo, c0_hi, c1_lo, c1_hi;
	out_item_t expected_rgb [$];

	function automatic logic [31:0] fx_product(input logic [31:0] a, input logic [31:0] b);
		logic signed [63:0] p;
		p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b}) + 64'sd32768;
		p = p >>> 16;
		return p[31:0];
	endfunction

	function automatic logic [7:0] minus_black(input logic [7:0] c, input logic [7:0] k);
		int s;
		s = int'(c) + int'(k);
		return (s >= 255) ? 8'd0 : 8'(255 - s);
	endfunction

	function automatic out_item_t to_rgb(input logic [1:0] space, input logic [7:0] v [4]);
		out_item_t o;
		case (space)
			MODE_GRAY: o = '{v[0], v[0], v[0]};
			MODE_RGB: o = '{v[0], v[1], v[2]};
			MODE_CMYK: o = '{minus_black(v[0], v[3]), minus_black(v[1], v[3]),
				minus_black(v[2], v[3])};
			default: o = '0;
		endcase
		return o;
	endfunction

	function automatic int active_count();
		if (comp_count == 0) return 1;
		if (comp_count > 4) return 4;
		return int'(comp_count);
	endfunction

	function automatic logic [31:0] coef_of(input logic [63:0] lo, input logic [63:0] hi,
			input int j);
		case (j)
			0: return lo[31:0];
			1: return lo[63:32];
			2: return hi[31:0];
			default: return hi[63:32];
		endcase
	endfunction

	function automatic out_item_t predict_rgb(input in_item_t it);
		logic [7:0] s [4];
		logic [7:0] v [4];
		logic [31:0] t, tp, acc, c0, c1;
		logic signed [31:0] ip;
		int n, sum;
		out_item_t o;
		s = '{it.sample_zero, it.sample_one, it.sample_two, it.sample_three};
		v = '{8'd0, 8'd0, 8'd0, 8'd0};
		n = active_count();
		o = '0;
		case (path_sel)
			PATH_IDENT: o = to_rgb(space_sel, s);
			PATH_FUNC: begin
				t = {8'd0, decode_rows[s[0]][0], 16'd0} / 32'd255;
				tp = t;
				if (exp_n >= 2 && exp_n <= 8)
					for (int i = 1; i < exp_n; i++) tp = fx_product(tp, t);
				for (int j = 0; j < n; j++) begin
					c0 = coef_of(c0_lo, c0_hi, j);
					c1 = coef_of(c1_lo, c1_hi, j);
					acc = c0 + fx_product(tp, c1 - c0);
					acc = fx_product(acc, 32'd255 << 16);
					ip = $signed(acc) >>> 16;
					v[j] = (ip < 0) ? 8'd0 : (ip > 255) ? 8'd255 : ip[7:0];
				end
				o = to_rgb(space_sel, v);
			end
			PATH_PAL: o = '{decode_rows[s[0]][0], decode_rows[s[0]][1], decode_rows[s[0]][2]};
			PATH_DEC: begin
				for (int k = 0; k < 4; k++) v[k] = decode_rows[s[k]][k];
				o = to_rgb(space_sel, v);
			end
			PATH_AVG: begin
				sum = 0;
				for (int k = 0; k < n; k++) sum += decode_rows[s[k]][k];
				v[0] = 8'(255 - sum / n);
				o = '{v[0], v[0], v[0]};
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			path_sel = 3'd0;
			space_sel = 2'd0;
			comp_count = 3'd1;
			exp_n = 4'd1;
			c0_lo = '0;
			c0_hi = '0;
			c1_lo = 64'd281479271743488;
			c1_hi = 64'd281479271743488;
			fail_count = 0;
			expected_rgb.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[5:3]))
					REG_PATH: path_sel = pwdata[2:0];
					REG_MODE: space_sel = pwdata[1:0];
					REG_COUNT: comp_count = pwdata[2:0];
					REG_EXP: exp_n = pwdata[3:0];
					REG_C0LO: c0_lo = pwdata;
					REG_C0HI: c0_hi = pwdata;
					REG_C1LO: c1_lo = pwdata;
					REG_C1HI: c1_hi = pwdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (in_data.command == CMD_WRITE)
					decode_rows[in_data.entry_index][in_data.entry_component] =
						in_data.entry_value;
				else
					expected_rgb.push_back(predict_rgb(in_data));
			end
			if (out_valid && out_ready) begin
				if (expected_rgb.size() == 0) begin
					fail_count++;
					$display("%0t: result with nothing expected, actual %h", $time, out_data);
				end else begin
					want = expected_rgb.pop_front();
					if (want.red !== out_data.red || want.green !== out_data.green ||
							want.blue !== out_data.blue) begin
						fail_count++;
						$display("%0t: expected rgb %h %h %h, actual %h %h %h", $time,
							want.red, want.green, want.blue,
							out_data.red, out_data.green, out_data.blue);
					end
				end
			end
		end
		pending = expected_rgb.size();
	end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

// Drives requests, register writes and result back-pressure into the colour mapper.
// The checker beside it does all the prediction; this module only decides when the
// run is over and whether it passed.
module tb_top;
	import iscm_pkg::*;

	localparam int StallLimit = 3000;
	localparam int InW = $bits(in_item_t);

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	in_item_t in_data;
	out_item_t out_data;
	logic psel, penable, pwrite, pready;
	logic [5:0] paddr;
	logic [63:0] pwdata, prdata;
	int fail_count, pending;
	int quiet_cycles;

	// Table cells that have been written; conversions only ever read these.
	bit written [256][4];
	logic [2:0] cur_path;
	logic [2:0] cur_count;
	bit no_gaps;

	image_sample_color_map uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	iscm_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: the run is abandoned once nothing has moved for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// Result back-pressure: mostly ready, with short stalls, the odd long one, and
	// whole stretches in which the consumer never stalls at all.
	initial begin
		int r;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			r = $urandom_range(0, 999);
			if (r < 5) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end else if (r < 10) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(50, 150)) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) < 75);
			end
		end
	end

	function automatic int idle_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offers one request and returns at the edge where it is accepted. Valid is only
	// lowered when a gap follows, so it is never dropped and raised in one step.
	task automatic offer(input in_item_t it);
		int gap;
		gap = idle_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		if (it.command == CMD_WRITE)
			written[it.entry_index][it.entry_component] = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Registers only change once the block has drained; a table write leaves no result
	// behind, so the pipeline length is waited out as well.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (Lat + 4) @(negedge clk);
	endtask

	function automatic in_item_t table_write(input logic [7:0] row, input logic [1:0] col,
			input logic [7:0] value);
		in_item_t it;
		it = in_item_t'(InW'($urandom()));
		it.command = CMD_WRITE;
		it.entry_index = row;
		it.entry_component = col;
		it.entry_value = value;
		return it;
	endfunction

	// A row whose cell in this column was written; on the palette path the three
	// colour columns of the first sample's row must all be present.
	function automatic logic [7:0] pick_row(input int col, input bit need_rgb);
		logic [7:0] r;
		for (int i = 0; i < 60; i++) begin
			r = 8'($urandom_range(0, 255));
			if (written[r][col] && (!need_rgb || (written[r][0] && written[r][1] &&
					written[r][2])))
				return r;
		end
		return 8'd0;
	endfunction

	function automatic in_item_t pixel();
		in_item_t it;
		it = in_item_t'(InW'({$urandom(), $urandom()}));
		it.command = CMD_CONVERT;
		if (cur_path != PATH_IDENT) begin
			it.sample_zero = pick_row(0, 1'b1);
			it.sample_one = pick_row(1, 1'b0);
			it.sample_two = pick_row(2, 1'b0);
			it.sample_three = pick_row(3, 1'b0);
		end
		return it;
	endfunction

	function automatic logic [63:0] coef_pair(input int phase);
		logic [31:0] a, b;
		if (phase == 1) return 64'hFFFF_FFFF_FFFF_FFFF;
		if (phase == 2) return 64'h7FFF_FFFF_8000_0000;
		if (phase == 3) return '0;
		if ($urandom_range(0, 3) != 0) begin
			a = $urandom_range(0, 32'h0001_4000) - 32'h0000_2000;
			b = $urandom_range(0, 32'h0001_4000) - 32'h0000_2000;
		end else begin
			a = $urandom();
			b = $urandom();
		end
		return {b, a};
	endfunction

	initial begin
		logic [7:0] corners [5];
		logic [2:0] mode_val;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet_cycles = 0;
		no_gaps = 1'b0;
		cur_path = PATH_IDENT;
		cur_count = 3'd1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: corner rows of every column, then three pixels with all-zero,
		// all-ones and mixed samples under the reset settings.
		corners = '{8'd0, 8'd255, 8'h55, 8'hAA, 8'h80};
		foreach (corners[i])
			for (int c = 0; c < 4; c++)
				offer(table_write(corners[i], 2'(c), (i % 2) ? 8'hFF : 8'(i * 37 + c)));
		offer('{CMD_CONVERT, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 2'd3, 8'hFF});
		offer('{CMD_CONVERT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 2'd0, 8'h00});
		offer('{CMD_CONVERT, 8'h55, 8'hAA, 8'h80, 8'h01, 8'hAA, 2'd1, 8'h55});

		// Sixteen settings walk every path, space, count and exponent code, including
		// the unused ones; coefficient extremes come in phases 1 to 3.
		for (int phase = 0; phase < 16; phase++) begin
			drain();
			cur_path = 3'(phase % 8);
			cur_count = 3'((phase * 3) % 8);
			mode_val = 3'(phase % 4);
			reg_write(REG_PATH, {61'd0, cur_path});
			reg_write(REG_MODE, {62'd0, mode_val[1:0]});
			reg_write(REG_COUNT, {61'd0, cur_count});
			reg_write(REG_EXP, {60'd0, 4'(15 - phase)});
			reg_write(REG_C0LO, coef_pair(phase));
			reg_write(REG_C0HI, coef_pair(phase));
			reg_write(REG_C1LO, coef_pair(phase == 3 ? 1 : phase));
			reg_write(REG_C1HI, coef_pair(phase));
			no_gaps = (phase % 5 == 4);
			for (int i = 0; i < 34; i++) begin
				if ($urandom_range(0, 3) == 0)
					offer(table_write(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
						8'($urandom_range(0, 255))));
				else
					offer(pixel());
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (Lat + 8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
